@@ rtl/core/bboe_pkg.sv @@
// Package for the brightness offset estimator.
// Holds the fixed field widths, register indexes and constants that the
// configuration block and the top level share. No dependencies.
`timescale 1ns / 1ps

package bboe_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned SIDE_REG_W  = 7;
  localparam int unsigned LIMIT_W     = 8;
  localparam int unsigned LIMIT_LO_W  = 7;
  localparam int unsigned OFFSET_W    = 9;

  // 255 * diff fits in this many bits.
  localparam int unsigned SCALED_W    = 16;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // limit / 3 for an 8-bit limit is (limit * 171) >> 9, exact over 0..255.
  localparam logic [LIMIT_W-1:0] THIRD_RECIP = 8'd171;
  localparam int unsigned        THIRD_SHIFT = 9;

  localparam logic [SIDE_REG_W-1:0] TILE_SIDE_RESET = 7'd16;
  localparam logic [LIMIT_W-1:0]    LIMIT_RESET     = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TILE_SIDE        = 8'd0,
    REG_BRIGHTNESS_LIMIT = 8'd1
  } cfg_reg_e;

endpackage

@@ rtl/core/bboe_div.sv @@
// Shared radix-2 restoring divider: one quotient bit per cycle.
// Serves both the per-pixel term division and the tile average division.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module bboe_div #(
  parameter int unsigned DIV_W = 32,
  parameter int unsigned DVS_W = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DIV_W-1:0] quo_q;

  logic [DVS_W:0]   partial;
  logic [DVS_W:0]   trial;
  logic             fits;

  // The dividend shifts out of the top of quo_q while quotient bits enter
  // at the bottom.
  assign partial = {rem_q, quo_q[DIV_W-1]};
  assign trial   = partial - {1'b0, dvs_q};
  assign fits    = ~trial[DVS_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial[DVS_W-1:0] : partial[DVS_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/core/bboe_cfg.sv @@
// Configuration registers of the brightness offset estimator.
// Derives the pixel count of a tile and the two clamp bounds.
// Depends on bboe_pkg.
`timescale 1ns / 1ps

module bboe_cfg #(
  parameter int unsigned MAX_TILE_SIDE = 64,
  parameter int unsigned CNT_W         = 13
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bboe_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bboe_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic [CNT_W-1:0]                    tile_pixels_o,
  output logic [bboe_pkg::LIMIT_W-1:0]        limit_hi_o,
  output logic [bboe_pkg::LIMIT_LO_W-1:0]     limit_lo_o
);

  localparam int unsigned SIDE_W =
    ($clog2(MAX_TILE_SIDE + 1) > bboe_pkg::SIDE_REG_W) ?
    $clog2(MAX_TILE_SIDE + 1) : bboe_pkg::SIDE_REG_W;
  localparam int unsigned PROD_W = 2 * bboe_pkg::LIMIT_W;

  logic [bboe_pkg::SIDE_REG_W-1:0] tile_side_q;
  logic [bboe_pkg::LIMIT_W-1:0]    limit_q;

  logic [SIDE_W-1:0]   side_ext;
  logic [SIDE_W-1:0]   side_eff;
  logic [2*SIDE_W-1:0] side_sq;
  logic [PROD_W-1:0]   third_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_side_q <= bboe_pkg::TILE_SIDE_RESET;
      limit_q     <= bboe_pkg::LIMIT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bboe_pkg::REG_TILE_SIDE:
          tile_side_q <= cfg_data_i[bboe_pkg::SIDE_REG_W-1:0];
        bboe_pkg::REG_BRIGHTNESS_LIMIT:
          limit_q <= cfg_data_i[bboe_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // A side of zero counts as one; a side above the maximum is capped.
  always_comb begin
    side_ext = SIDE_W'(tile_side_q);
    if (side_ext == '0) begin
      side_eff = SIDE_W'(1);
    end else if (side_ext > SIDE_W'(MAX_TILE_SIDE)) begin
      side_eff = SIDE_W'(MAX_TILE_SIDE);
    end else begin
      side_eff = side_ext;
    end
  end

  assign side_sq       = side_eff * side_eff;
  assign tile_pixels_o = CNT_W'(side_sq);

  assign third_prod  = limit_q * bboe_pkg::THIRD_RECIP;
  assign limit_hi_o  = limit_q;
  assign limit_lo_o  =
    third_prod[bboe_pkg::THIRD_SHIFT +: bboe_pkg::LIMIT_LO_W];
  assign cfg_ready_o = 1'b1;

endmodule

@@ rtl/core/best_brightness_offset_estimator_unit.sv @@
// Brightness offset estimator: one pixel pair per beat, one offset per tile.
// Each pixel runs its term through the shared bit-serial divider, and the
// next pixel is taken only once that division is done. The last pixel of a
// tile runs the same divider again for the average, and the next pixel waits
// for the offset to enter the output register, later still while an earlier
// offset sits stalled there. Reset clears the sum, the count and the output,
// and loads tile side 16 and limit 0.
`timescale 1ns / 1ps

module best_brightness_offset_estimator_unit #(
  parameter int unsigned MAX_TILE_SIDE = 64,
  parameter int unsigned FRAC_BITS     = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [bboe_pkg::PIX_W-1:0]             target_pixel_i,
  input  logic [bboe_pkg::PIX_W-1:0]             candidate_pixel_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [bboe_pkg::OFFSET_W-1:0]   brightness_offset_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [bboe_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [bboe_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int unsigned CNT_W  = $clog2(MAX_TILE_SIDE * MAX_TILE_SIDE + 1);
  localparam int unsigned NUM_W  = bboe_pkg::SCALED_W + FRAC_BITS;
  localparam int unsigned TERM_W = NUM_W + 1;
  localparam int unsigned SUM_W  = NUM_W + CNT_W + 1;
  localparam int unsigned AVG_W  = SUM_W - FRAC_BITS;
  localparam int unsigned DIV_W  = (NUM_W > AVG_W) ? NUM_W : AVG_W;
  localparam int unsigned DVS_W  =
    (CNT_W > bboe_pkg::PIX_W) ? CNT_W : bboe_pkg::PIX_W;
  localparam int unsigned OW     = bboe_pkg::OFFSET_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TERM,
    S_CHECK,
    S_AVG,
    S_EMIT
  } state_e;

  state_e state_q;

  logic [CNT_W-1:0]               tile_pixels;
  logic [bboe_pkg::LIMIT_W-1:0]   limit_hi;
  logic [bboe_pkg::LIMIT_LO_W-1:0] limit_lo;

  logic                 div_start;
  logic [DIV_W-1:0]     div_dividend;
  logic [DVS_W-1:0]     div_divisor;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quotient;

  logic                 in_accept;
  logic                 tile_done;
  logic                 pix_lt;
  logic                 pix_eq;
  logic [bboe_pkg::PIX_W-1:0]    pix_diff;
  logic [bboe_pkg::PIX_W-1:0]    pix_den;
  logic [bboe_pkg::SCALED_W-1:0] scaled_diff;
  logic [NUM_W-1:0]     term_num;

  logic                 term_neg_q;
  logic                 term_zero_q;
  logic signed [SUM_W-1:0] term_sum_q;
  logic [CNT_W-1:0]     pixel_count_q;
  logic                 avg_neg_q;
  logic [OW-1:0]        result_q;
  logic                 out_valid_q;
  logic [OW-1:0]        offset_q;

  logic [NUM_W-1:0]     term_mag;
  logic [TERM_W-1:0]    term_val;
  logic [SUM_W-1:0]     term_ext;
  logic [SUM_W-1:0]     sum_abs;
  logic [OW-1:0]        clamped;

  bboe_cfg #(
    .MAX_TILE_SIDE(MAX_TILE_SIDE),
    .CNT_W        (CNT_W)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .tile_pixels_o(tile_pixels),
    .limit_hi_o   (limit_hi),
    .limit_lo_o   (limit_lo)
  );

  bboe_div #(
    .DIV_W(DIV_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quotient)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign tile_done  = (pixel_count_q >= tile_pixels);

  // Term operands: a darker target divides by the candidate, a brighter one
  // by the candidate's distance to white.
  assign pix_lt      = target_pixel_i < candidate_pixel_i;
  assign pix_eq      = target_pixel_i == candidate_pixel_i;
  assign pix_diff    = pix_lt ? (candidate_pixel_i - target_pixel_i)
                              : (target_pixel_i - candidate_pixel_i);
  assign pix_den     = pix_lt ? candidate_pixel_i
                              : (bboe_pkg::PIX_MAX - candidate_pixel_i);
  assign scaled_diff = {pix_diff, {bboe_pkg::PIX_W{1'b0}}}
                       - bboe_pkg::SCALED_W'(pix_diff);
  assign term_num    = {scaled_diff, {FRAC_BITS{1'b0}}};

  assign sum_abs = term_sum_q[SUM_W-1] ? (SUM_W'(0) - SUM_W'(term_sum_q))
                                       : SUM_W'(term_sum_q);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_W'(term_num);
    div_divisor  = DVS_W'(pix_den);
    if (in_accept) begin
      div_start = 1'b1;
    end else if (state_q == S_CHECK && tile_done) begin
      div_start    = 1'b1;
      div_dividend = DIV_W'(sum_abs[SUM_W-1:FRAC_BITS]);
      div_divisor  = DVS_W'(tile_pixels);
    end
  end

  assign term_mag = term_zero_q ? '0 : div_quotient[NUM_W-1:0];
  assign term_val = term_neg_q ? (TERM_W'(0) - {1'b0, term_mag})
                               : {1'b0, term_mag};
  assign term_ext = {{(SUM_W - TERM_W){term_val[TERM_W-1]}}, term_val};

  // Clamp the average magnitude against the bound on its own side.
  always_comb begin
    if (avg_neg_q) begin
      if (div_quotient > DIV_W'(limit_lo)) begin
        clamped = OW'(0) - OW'(limit_lo);
      end else begin
        clamped = OW'(0) - OW'(div_quotient[bboe_pkg::LIMIT_LO_W-1:0]);
      end
    end else begin
      if (div_quotient > DIV_W'(limit_hi)) begin
        clamped = OW'(limit_hi);
      end else begin
        clamped = OW'(div_quotient[bboe_pkg::LIMIT_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      term_sum_q    <= '0;
      pixel_count_q <= '0;
      out_valid_q   <= 1'b0;
      term_neg_q    <= 1'b0;
      term_zero_q   <= 1'b0;
      avg_neg_q     <= 1'b0;
      result_q      <= '0;
      offset_q      <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            term_neg_q  <= pix_lt;
            term_zero_q <= pix_eq;
            state_q     <= S_TERM;
          end
        end
        S_TERM: begin
          if (div_done) begin
            term_sum_q    <= term_sum_q + $signed(term_ext);
            pixel_count_q <= pixel_count_q + CNT_W'(1);
            state_q       <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (tile_done) begin
            avg_neg_q <= term_sum_q[SUM_W-1];
            state_q   <= S_AVG;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_AVG: begin
          if (div_done) begin
            result_q      <= clamped;
            term_sum_q    <= '0;
            pixel_count_q <= '0;
            state_q       <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Load the output register once the previous beat has left.
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            offset_q    <= result_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign brightness_offset_o = $signed(offset_q);

endmodule

@@ dv/brightness_offset_checker.sv @@
// Checker for the brightness offset estimator: watches the pixel, offset and
// register channels, predicts each tile's offset and compares it with the beat
// that comes out. Depends on bboe_pkg.
`timescale 1ns / 1ps

module brightness_offset_checker
  import bboe_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [PIX_W-1:0]           target_pixel_i,
  input  logic [PIX_W-1:0]           candidate_pixel_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic signed [OFFSET_W-1:0] brightness_offset_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  output int                         error_count_o,
  output int                         offsets_pending_o
);

  localparam longint MAX_SIDE  = 64;
  localparam int     FRAC_BITS = 16;

  logic [SIDE_REG_W-1:0]       side_q;
  logic [LIMIT_W-1:0]          limit_q;
  longint                      tile_sum;
  longint                      tile_count;
  logic signed [OFFSET_W-1:0]  expected_offsets[$];
  logic signed [OFFSET_W-1:0]  oldest_offset;
  int                          errors;

  // Fixed-point brightness term of one pixel pair, truncated toward zero.
  function automatic longint pixel_brightness_term(logic [PIX_W-1:0] t, logic [PIX_W-1:0] c);
    longint diff;
    longint divisor;
    longint mag;
    if (t == c) return 0;
    if (t < c) begin
      diff    = longint'(c) - longint'(t);
      divisor = longint'(c);
      mag     = ((255 * diff) <<< FRAC_BITS) / divisor;
      return -mag;
    end
    diff    = longint'(t) - longint'(c);
    divisor = longint'(PIX_MAX) - longint'(c);
    mag     = ((255 * diff) <<< FRAC_BITS) / divisor;
    return mag;
  endfunction

  function automatic longint tile_area(logic [SIDE_REG_W-1:0] side);
    longint s;
    s = longint'(side);
    if (s < 1) s = 1;
    if (s > MAX_SIDE) s = MAX_SIDE;
    return s * s;
  endfunction

  function automatic logic signed [OFFSET_W-1:0] clamped_tile_offset(longint sum, longint area,
                                                                     logic [LIMIT_W-1:0] limit);
    longint scale;
    longint avg;
    longint lo;
    longint hi;
    scale = area <<< FRAC_BITS;
    if (sum < 0) avg = -((-sum) / scale);
    else avg = sum / scale;
    lo = -(longint'(limit) / 3);
    hi = longint'(limit);
    if (avg < lo) avg = lo;
    if (avg > hi) avg = hi;
    return avg[OFFSET_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q     = TILE_SIDE_RESET;
      limit_q    = LIMIT_RESET;
      tile_sum   = 0;
      tile_count = 0;
      errors     = 0;
      expected_offsets.delete();
      error_count_o     <= 0;
      offsets_pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_TILE_SIDE) side_q = cfg_data_i[SIDE_REG_W-1:0];
        else if (cfg_index_i == REG_BRIGHTNESS_LIMIT) limit_q = cfg_data_i;
      end

      if (out_valid_i && !out_stall_i) begin
        if (expected_offsets.size() == 0) begin
          errors++;
          $display("%0t: offset beat %0d arrived with none expected",
                   $time, brightness_offset_i);
        end else begin
          oldest_offset = expected_offsets.pop_front();
          if (oldest_offset !== brightness_offset_i) begin
            errors++;
            $display("%0t: brightness_offset expected %0d, got %0d",
                     $time, oldest_offset, brightness_offset_i);
          end
        end
      end

      // A register written in mid tile keeps the running sum; the tile closes
      // as soon as the count reaches or passes the current tile size.
      if (in_valid_i && !in_stall_i) begin
        tile_sum += pixel_brightness_term(target_pixel_i, candidate_pixel_i);
        tile_count++;
        if (tile_count >= tile_area(side_q)) begin
          expected_offsets.push_back(clamped_tile_offset(tile_sum, tile_area(side_q), limit_q));
          tile_sum   = 0;
          tile_count = 0;
        end
      end

      error_count_o     <= errors;
      offsets_pending_o <= expected_offsets.size();
    end
  end

endmodule

@@ dv/testbench.sv @@
// Top of the brightness offset estimator testbench: clock, reset, pixel and
// register stimulus, output stall and the verdict. Depends on bboe_pkg, the
// estimator RTL and brightness_offset_checker.
`timescale 1ns / 1ps

module testbench;
  import bboe_pkg::*;

  localparam int                   SETTLE_CYCLES      = 80;
  localparam int                   NUM_PHASES         = 16;
  localparam int                   PIXELS_PER_PHASE   = 116;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_UNMAPPED = 8'hA5;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [PIX_W-1:0]           target_pixel = '0;
  logic [PIX_W-1:0]           candidate_pixel = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [OFFSET_W-1:0] brightness_offset;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  int                         error_count;
  int                         offsets_pending;
  int                         idle_pct = 0;
  int                         stall_pct = 0;

  // Target high byte, candidate low byte.
  logic [15:0] corner_pairs [12] = '{
    16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h0001, 16'h0100,
    16'hFEFF, 16'hFFFE, 16'h807F, 16'h7F80, 16'h55AA, 16'hAA55
  };

  always #4 clk = ~clk;

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  best_brightness_offset_estimator_unit u_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .target_pixel_i      (target_pixel),
    .candidate_pixel_i   (candidate_pixel),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .brightness_offset_o (brightness_offset),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  brightness_offset_checker u_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .target_pixel_i      (target_pixel),
    .candidate_pixel_i   (candidate_pixel),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .brightness_offset_i (brightness_offset),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_i         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .error_count_o       (error_count),
    .offsets_pending_o   (offsets_pending)
  );

  task automatic send_pixel(input logic [PIX_W-1:0] t, input logic [PIX_W-1:0] c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    target_pixel    <= t;
    candidate_pixel <= c;
    do @(posedge clk); while (in_stall);
  endtask

  // Waits for every pending offset and for the divider to finish, then writes.
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (offsets_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly pairs with a shared brightness shift so tile averages spread out,
  // plus equal pairs, extremes and plain noise.
  task automatic send_shaped_pixel(input int bias);
    int kind;
    int c;
    int t;
    kind = $urandom_range(9);
    c    = $urandom_range(255);
    if (kind < 2) begin
      t = $urandom_range(255);
    end else if (kind == 2) begin
      t = c;
    end else if (kind == 3) begin
      t = $urandom_range(1) ? 255 : 0;
      if ($urandom_range(1)) c = $urandom_range(1) ? 255 : 0;
    end else begin
      t = c + bias + $urandom_range(16) - 8;
      if (t < 0) t = 0;
      if (t > 255) t = 255;
    end
    send_pixel(t[PIX_W-1:0], c[PIX_W-1:0]);
  endtask

  initial begin
    int phase;
    int i;
    int pick;
    int bias;
    logic [CFG_DATA_W-1:0] side;
    logic [CFG_DATA_W-1:0] limit;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: a partial tile of 16 x 16, closed early by a side of one.
    send_pixel(8'd200, 8'd10);
    send_pixel(8'd3, 8'd250);
    write_register(REG_TILE_SIDE, 8'd1);
    send_pixel(8'd255, 8'd0);

    write_register(REG_BRIGHTNESS_LIMIT, 8'd255);
    foreach (corner_pairs[k]) send_pixel(corner_pairs[k][15:8], corner_pairs[k][7:0]);

    write_register(REG_BRIGHTNESS_LIMIT, 8'd0);
    send_pixel(8'd255, 8'd0);
    send_pixel(8'd0, 8'd255);
    write_register(REG_BRIGHTNESS_LIMIT, 8'd3);
    send_pixel(8'd0, 8'd255);
    send_pixel(8'd255, 8'd0);

    // Side zero acts as one; an unmapped index must change nothing.
    write_register(REG_TILE_SIDE, 8'd0);
    send_pixel(8'd10, 8'd20);
    write_register(CFG_INDEX_UNMAPPED, 8'h07);
    send_pixel(8'd30, 8'd20);

    // Bit 7 of the data lies outside the tile side register.
    write_register(REG_TILE_SIDE, 8'h82);
    send_pixel(8'd90, 8'd40);
    send_pixel(8'd60, 8'd180);

    // Oversized side, then a smaller one in mid tile.
    write_register(REG_TILE_SIDE, 8'd127);
    send_pixel(8'd1, 8'd254);
    send_pixel(8'd254, 8'd1);
    send_pixel(8'd77, 8'd66);
    write_register(REG_TILE_SIDE, 8'd2);
    send_pixel(8'd12, 8'd34);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      pick = $urandom_range(19);
      if (pick < 12) side = CFG_DATA_W'($urandom_range(1, 4));
      else if (pick < 16) side = CFG_DATA_W'($urandom_range(5, 8));
      else if (pick < 18) side = 8'd16;
      else if (pick == 18) side = 8'd0;
      else side = $urandom_range(1) ? 8'd64 : 8'd127;
      if ($urandom_range(1)) side[7] = 1'b1;

      pick = $urandom_range(7);
      if (pick == 0) limit = 8'd0;
      else if (pick == 1) limit = 8'd255;
      else limit = CFG_DATA_W'($urandom_range(255));

      write_register(REG_TILE_SIDE, side);
      write_register(REG_BRIGHTNESS_LIMIT, limit);

      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase

      bias = 0;
      for (i = 0; i < PIXELS_PER_PHASE; i++) begin
        if (i % 32 == 0) bias = $urandom_range(256) - 128;
        send_shaped_pixel(bias);
      end
      idle_pct  = 0;
      stall_pct = 0;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (offsets_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/bboe_pkg.sv
rtl/core/bboe_div.sv
rtl/core/bboe_cfg.sv
rtl/core/best_brightness_offset_estimator_unit.sv
dv/brightness_offset_checker.sv
dv/testbench.sv
